[rtl/blit_pkg.sv]
// Package for the 16bpp color-keyed blitter: register indexes, option bits,
// field widths and default parameter values. No dependencies.
package blit_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int ADDR_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BASE_W     = 32;
  localparam int PITCH_W    = 16;
  localparam int CFG_DIM_W  = 13;
  localparam int OPT_W      = 3;
  localparam int PIXEL_W    = 16;
  localparam int OUT_ADDR_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_BASE     = 3'd0,
    REG_DST_BASE     = 3'd1,
    REG_SRC_PITCH    = 3'd2,
    REG_DST_PITCH    = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_BLIT_OPTIONS = 3'd6,
    REG_COLOR_KEY    = 3'd7
  } cfg_reg_t;

  localparam int OPT_MIRROR_X = 0;
  localparam int OPT_MIRROR_Y = 1;
  localparam int OPT_KEYED    = 2;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_START = 1'b1;

endpackage

[rtl/blit_16bpp_flip_colorkey_top.sv]
// 16bpp 2D blitter with X/Y mirroring and color-key transparency; uses blit_pkg.
// A request's result is in the output register in the cycle after it is accepted.
// Throughput: one request per cycle; the walk counters and address adders update in
// the accepting cycle, and the input stalls only while a waiting result is stalled.
// Reset (synchronous, rst_n low): registers to defaults (width and height 1), walk idle,
// output register empty.
module blit_16bpp_flip_colorkey_top
  import blit_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [PIXEL_W-1:0]     in_pixel_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_ADDR_W-1:0]  out_read_address,
  output logic                   out_read_valid,
  output logic [OUT_ADDR_W-1:0]  out_write_address,
  output logic [PIXEL_W-1:0]     out_write_data,
  output logic                   out_write_enable,
  output logic                   out_last
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = CNT_W + 1;
  localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int PROD_W = PITCH_W + DIM_W;

  // Configuration registers; width and height are stored already clamped.
  logic [BASE_W-1:0]  src_base_r, dst_base_r;
  logic [PITCH_W-1:0] src_pitch_r, dst_pitch_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [OPT_W-1:0]   options_r;
  logic [PIXEL_W-1:0] key_r;

  // Walk state.
  logic [CNT_W-1:0]     col_r, col_nxt;
  logic [CNT_W-1:0]     row_r, row_nxt;
  logic [ADDR_BITS-1:0] src_row_r, src_row_nxt;
  logic [ADDR_BITS-1:0] dst_row_r, dst_row_nxt;
  logic [ADDR_BITS-1:0] src_pix_r, src_pix_nxt;
  logic [ADDR_BITS-1:0] dst_pix_r, dst_pix_nxt;
  logic                 active_r, active_nxt;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic [OUT_ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [PIXEL_W-1:0]    wr_data_r, wr_data_nxt;
  logic                  wr_en_r, wr_en_nxt;
  logic                  last_r, last_nxt;

  logic                 accept;
  logic [CFG_DIM_W-1:0] cfg_dim;
  logic [DIM_W-1:0]     cfg_dim_clamped;
  logic [DIM_W-1:0]     w_m1, h_m1;
  logic [PROD_W-1:0]    pitch_prod;
  logic [ADDR_BITS-1:0] start_src;
  logic [ADDR_BITS-1:0] src_col_step;
  logic [ADDR_BITS-1:0] src_row_step;
  logic                 row_end, is_last;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Clamp a dimension write into 1..MAX_DIM.
  assign cfg_dim = cfg_data[CFG_DIM_W-1:0];
  always_comb begin
    if (cfg_dim == '0) begin
      cfg_dim_clamped = DIM_W'(1);
    end else if (CMP_W'(cfg_dim) > CMP_W'(MAX_DIM)) begin
      cfg_dim_clamped = DIM_W'(MAX_DIM);
    end else begin
      cfg_dim_clamped = DIM_W'(cfg_dim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r  <= '0;
      dst_base_r  <= '0;
      src_pitch_r <= '0;
      dst_pitch_r <= '0;
      width_r     <= DIM_W'(1);
      height_r    <= DIM_W'(1);
      options_r   <= '0;
      key_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_BASE:     src_base_r  <= cfg_data[BASE_W-1:0];
        REG_DST_BASE:     dst_base_r  <= cfg_data[BASE_W-1:0];
        REG_SRC_PITCH:    src_pitch_r <= cfg_data[PITCH_W-1:0];
        REG_DST_PITCH:    dst_pitch_r <= cfg_data[PITCH_W-1:0];
        REG_RECT_WIDTH:   width_r     <= cfg_dim_clamped;
        REG_RECT_HEIGHT:  height_r    <= cfg_dim_clamped;
        REG_BLIT_OPTIONS: options_r   <= cfg_data[OPT_W-1:0];
        REG_COLOR_KEY:    key_r       <= cfg_data[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // First source pixel: mirroring starts at the far column and/or row.
  assign w_m1       = width_r - DIM_W'(1);
  assign h_m1       = height_r - DIM_W'(1);
  assign pitch_prod = PROD_W'(src_pitch_r) * PROD_W'(h_m1);
  always_comb begin
    start_src = ADDR_BITS'(src_base_r);
    if (options_r[OPT_MIRROR_X]) begin
      start_src = start_src + ADDR_BITS'({w_m1, 1'b0});
    end
    if (options_r[OPT_MIRROR_Y]) begin
      start_src = start_src + ADDR_BITS'(pitch_prod);
    end
  end

  assign src_col_step = options_r[OPT_MIRROR_X] ? src_pix_r - ADDR_BITS'(2)
                                                : src_pix_r + ADDR_BITS'(2);
  assign src_row_step = options_r[OPT_MIRROR_Y] ? src_row_r - ADDR_BITS'(src_pitch_r)
                                                : src_row_r + ADDR_BITS'(src_pitch_r);

  assign row_end = (DIM_W'(col_r) + DIM_W'(1)) >= width_r;
  assign is_last = row_end && ((DIM_W'(row_r) + DIM_W'(1)) >= height_r);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    src_row_nxt  = src_row_r;
    dst_row_nxt  = dst_row_r;
    src_pix_nxt  = src_pix_r;
    dst_pix_nxt  = dst_pix_r;
    active_nxt   = active_r;
    rd_addr_nxt  = '0;
    rd_valid_nxt = 1'b0;
    wr_addr_nxt  = '0;
    wr_data_nxt  = '0;
    wr_en_nxt    = 1'b0;
    last_nxt     = 1'b0;
    if (in_mode == MODE_START) begin
      src_row_nxt  = start_src;
      src_pix_nxt  = start_src;
      dst_row_nxt  = ADDR_BITS'(dst_base_r);
      dst_pix_nxt  = ADDR_BITS'(dst_base_r);
      col_nxt      = '0;
      row_nxt      = '0;
      active_nxt   = 1'b1;
      rd_addr_nxt  = OUT_ADDR_W'(start_src);
      rd_valid_nxt = 1'b1;
    end else if (active_r) begin
      wr_addr_nxt = OUT_ADDR_W'(dst_pix_r);
      wr_data_nxt = in_pixel_in;
      wr_en_nxt   = !(options_r[OPT_KEYED] && (in_pixel_in == key_r));
      last_nxt    = is_last;
      if (is_last) begin
        active_nxt = 1'b0;
        col_nxt    = '0;
        row_nxt    = '0;
      end else begin
        if (row_end) begin
          col_nxt     = '0;
          row_nxt     = row_r + CNT_W'(1);
          src_row_nxt = src_row_step;
          dst_row_nxt = dst_row_r + ADDR_BITS'(dst_pitch_r);
          src_pix_nxt = src_row_step;
          dst_pix_nxt = dst_row_r + ADDR_BITS'(dst_pitch_r);
        end else begin
          col_nxt     = col_r + CNT_W'(1);
          src_pix_nxt = src_col_step;
          dst_pix_nxt = dst_pix_r + ADDR_BITS'(2);
        end
        rd_addr_nxt  = OUT_ADDR_W'(src_pix_nxt);
        rd_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      src_row_r <= '0;
      dst_row_r <= '0;
      src_pix_r <= '0;
      dst_pix_r <= '0;
      active_r  <= 1'b0;
    end else if (accept) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      src_row_r <= src_row_nxt;
      dst_row_r <= dst_row_nxt;
      src_pix_r <= src_pix_nxt;
      dst_pix_r <= dst_pix_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr_r  <= rd_addr_nxt;
      rd_valid_r <= rd_valid_nxt;
      wr_addr_r  <= wr_addr_nxt;
      wr_data_r  <= wr_data_nxt;
      wr_en_r    <= wr_en_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_address  = rd_addr_r;
  assign out_read_valid    = rd_valid_r;
  assign out_write_address = wr_addr_r;
  assign out_write_data    = wr_data_r;
  assign out_write_enable  = wr_en_r;
  assign out_last          = last_r;

`ifndef SYNTH
  // The final pixel of a rectangle never asks for another fetch.
  a_last_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_read_valid)
    else $error("last result still requests a read");

  // A start request always leaves a walk in progress at the first position.
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_START) |=> active_r && (col_r == '0) && (row_r == '0))
    else $error("start request did not begin a walk");

  // An idle walker keeps its position counters at zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (col_r == '0) && (row_r == '0))
    else $error("position counters nonzero while idle");

  // A pixel request while idle produces an all-zero result.
  a_idle_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == MODE_PIXEL) && !active_r |=>
      !out_read_valid && !out_write_enable && !out_last)
    else $error("pixel while idle produced a write or read");
`endif

endmodule
